// ----- sv/srafd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and result packing for the static route / ARP decision block.
// No dependencies; used by the top level, both checkers and the testbench.
package srafd_pkg;

    localparam int IN_W   = 256;
    localparam int OUT_W  = 104;
    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int PORT_W = 4;
    localparam int ACT_W  = 3;
    localparam int SLOT_SPAN = 16;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam logic [1:0] OP_LOCAL = 2'd0;
    localparam logic [1:0] OP_ROUTE = 2'd1;
    localparam logic [1:0] OP_ARP   = 2'd2;
    localparam logic [1:0] OP_FWD   = 2'd3;

    localparam logic [2:0] ACT_WRITTEN   = 3'd0;
    localparam logic [2:0] ACT_NOT_LOCAL = 3'd1;
    localparam logic [2:0] ACT_NOT_IPV4  = 3'd2;
    localparam logic [2:0] ACT_NO_ARP    = 3'd3;
    localparam logic [2:0] ACT_SELF      = 3'd4;
    localparam logic [2:0] ACT_UNICAST   = 3'd5;
    localparam logic [2:0] ACT_FLOOD     = 3'd6;
    localparam logic [2:0] ACT_FLOOD_0   = 3'd7;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_WR   = 10'b00_0000_0010,
        ST_L1   = 10'b00_0000_0100,
        ST_R1   = 10'b00_0000_1000,
        ST_A1   = 10'b00_0001_0000,
        ST_L2   = 10'b00_0010_0000,
        ST_FA   = 10'b00_0100_0000,
        ST_FG   = 10'b00_1000_0000,
        ST_FL   = 10'b01_0000_0000,
        ST_FE   = 10'b10_0000_0000
    } t_state;

    function automatic logic [OUT_W-1:0] pack_out(
        input logic [ACT_W-1:0]  action,
        input logic [PORT_W-1:0] port,
        input logic [MAC_W-1:0]  dmac,
        input logic [MAC_W-1:0]  smac
    );
        pack_out = {1'b0, smac, dmac, port, action};
    endfunction

endpackage

// ----- sv/srafd_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srafd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ----- sv/srafd_cmp.sv -----
`timescale 1ns / 1ps
// Shared equality compare unit used by every table scan.
// No dependencies.
module srafd_cmp #(
    parameter int WIDTH = 48
) (
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_eq
);
    assign o_eq = i_en && (i_a == i_b);
endmodule

// ----- sv/static_route_arp_forward_decision_top.sv -----
`timescale 1ns / 1ps
// Static route and ARP next-hop decision, top level with its scan sequencer.
// Depends on srafd_pkg, srafd_ram and srafd_cmp.
//
// The block holds three tables in RAM (local MACs, static routes, ARP entries) and takes
// one request at a time on the slave stream. A table-write request passes through the
// write state and answers one acknowledge. A forward request is resolved by linear scans
// through the tables, one entry per address phase and evaluate phase (the registered RAM
// read, then the shared compare unit): local MAC check, route by destination, ARP by
// gateway and a second local MAC check. When no route matches, the flood walk visits the
// first min(A,16) ARP entries; each valid one that is not the frame's source gets a
// gateway route scan and, on a match, a local scan. Each flood copy is held back one
// step so the final copy can carry tlast. Results leave through a single output
// register; the sequencer pauses on a stalled master side. Table contents need no
// clearing after reset: per-entry valid bits in flip-flops gate every match.
module static_route_arp_forward_decision_top #(
    parameter int LOCAL_ENTRIES = 16,
    parameter int ROUTE_ENTRIES = 16,
    parameter int ARP_ENTRIES   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // opcode, slot, key_ip, gateway_ip, mac_value, port_num, frame_dst_mac,
    // frame_type, frame_src_ip, frame_dst_ip (lowest bits first), zero padded
    input  logic [255:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // action, out_port, new_dst_mac, new_src_mac (lowest bits first), zero padded
    output logic [103:0] o_m_tdata,
    output logic         o_m_tlast
);
    localparam int LAW = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
    localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int AAW = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int CW0 = (LAW > RAW) ? LAW : RAW;
    localparam int CW  = (CW0 > AAW) ? CW0 : AAW;
    localparam int FLOOD_N = (ARP_ENTRIES < srafd_pkg::SLOT_SPAN) ? ARP_ENTRIES
                                                                  : srafd_pkg::SLOT_SPAN;
    localparam int RWW = 2 * srafd_pkg::IP_W + srafd_pkg::PORT_W;
    localparam int AWW = srafd_pkg::IP_W + srafd_pkg::MAC_W;

    // sequencer state, request fields (key, gateway, MAC and port are reloaded by scans) and output register
    srafd_pkg::t_state r_state, n_state;
    logic              r_ph, n_ph;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AAW-1:0]    r_fi, n_fi;
    logic [1:0]        r_op, n_op;
    logic [3:0]        r_slot, n_slot;
    logic [31:0]       r_key, n_key;
    logic [31:0]       r_gw, n_gw;
    logic [47:0]       r_amac, n_amac;
    logic [3:0]        r_port, n_port;
    logic [47:0]       r_dmac, n_dmac;
    logic [15:0]       r_ftype, n_ftype;
    logic [31:0]       r_sip, n_sip;
    logic [31:0]       r_dip, n_dip;
    logic              r_pend, n_pend;
    logic [3:0]        r_pport, n_pport;
    logic [47:0]       r_pmac, n_pmac;
    logic              r_ovalid, n_ovalid;
    logic [103:0]      r_odata, n_odata;
    logic              r_olast, n_olast;

    logic [LOCAL_ENTRIES-1:0] r_lv;
    logic [ROUTE_ENTRIES-1:0] r_rv;
    logic [ARP_ENTRIES-1:0]   r_av;

    logic [47:0]    lram_q;
    logic [RWW-1:0] rram_q;
    logic [AWW-1:0] aram_q;
    logic [LAW-1:0] l_i;
    logic [RAW-1:0] r_i;
    logic [AAW-1:0] a_i, a_rd;
    logic           l_last, r_last, a_last, fi_last;
    logic           out_free, in_acc;
    logic           l_we, r_we, a_we;
    logic           cmp_en, cmp_eq;
    logic [47:0]    cmp_a, cmp_b;
    logic [31:0]    rq_dest, rq_gw, aq_ip;
    logic [3:0]     rq_port;
    logic [47:0]    aq_mac;

    assign l_i = r_idx[LAW-1:0];
    assign r_i = r_idx[RAW-1:0];
    assign a_i = r_idx[AAW-1:0];
    assign a_rd = (r_state == srafd_pkg::ST_FA) ? r_fi : a_i;
    assign l_last  = (r_idx == CW'(LOCAL_ENTRIES - 1));
    assign r_last  = (r_idx == CW'(ROUTE_ENTRIES - 1));
    assign a_last  = (r_idx == CW'(ARP_ENTRIES - 1));
    assign fi_last = (r_fi == AAW'(FLOOD_N - 1));

    assign {rq_port, rq_gw, rq_dest} = rram_q;
    assign {aq_mac, aq_ip} = aram_q;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == srafd_pkg::ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    // table writes land on the acknowledge cycle; out-of-range slots are dropped
    always_comb begin
        l_we = 1'b0;
        r_we = 1'b0;
        a_we = 1'b0;
        if (r_state == srafd_pkg::ST_WR && out_free) begin
            l_we = (r_op == srafd_pkg::OP_LOCAL) && (7'(r_slot) < 7'(LOCAL_ENTRIES));
            r_we = (r_op == srafd_pkg::OP_ROUTE) && (7'(r_slot) < 7'(ROUTE_ENTRIES));
            a_we = (r_op == srafd_pkg::OP_ARP)   && (7'(r_slot) < 7'(ARP_ENTRIES));
        end
    end

    srafd_ram #(.WIDTH(48), .DEPTH(LOCAL_ENTRIES)) u_local_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(LAW'(r_slot)), .i_wdata(r_amac),
        .i_raddr(l_i), .o_rdata(lram_q)
    );

    srafd_ram #(.WIDTH(RWW), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(RAW'(r_slot)), .i_wdata({r_port, r_gw, r_key}),
        .i_raddr(r_i), .o_rdata(rram_q)
    );

    srafd_ram #(.WIDTH(AWW), .DEPTH(ARP_ENTRIES)) u_arp_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(AAW'(r_slot)), .i_wdata({r_amac, r_key}),
        .i_raddr(a_rd), .o_rdata(aram_q)
    );

    // operand select for the shared compare unit
    always_comb begin
        cmp_en = 1'b0;
        cmp_a  = '0;
        cmp_b  = '0;
        unique case (r_state)
            srafd_pkg::ST_L1: begin
                cmp_en = r_lv[l_i]; cmp_a = lram_q; cmp_b = r_dmac;
            end
            srafd_pkg::ST_L2, srafd_pkg::ST_FL: begin
                cmp_en = r_lv[l_i]; cmp_a = lram_q; cmp_b = r_amac;
            end
            srafd_pkg::ST_R1: begin
                cmp_en = r_rv[r_i]; cmp_a = {16'd0, rq_dest}; cmp_b = {16'd0, r_dip};
            end
            srafd_pkg::ST_FG: begin
                cmp_en = r_rv[r_i]; cmp_a = {16'd0, rq_gw}; cmp_b = {16'd0, r_key};
            end
            srafd_pkg::ST_A1: begin
                cmp_en = r_av[a_i]; cmp_a = {16'd0, aq_ip}; cmp_b = {16'd0, r_gw};
            end
            srafd_pkg::ST_FA: begin
                cmp_en = 1'b1; cmp_a = {16'd0, aq_ip}; cmp_b = {16'd0, r_sip};
            end
            default: begin
                cmp_en = 1'b0;
            end
        endcase
    end

    srafd_cmp #(.WIDTH(48)) u_cmp (
        .i_en(cmp_en), .i_a(cmp_a), .i_b(cmp_b), .o_eq(cmp_eq)
    );

    // sequencer: phase 0 presents the RAM address, phase 1 evaluates the entry
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_idx   = r_idx;
        n_fi    = r_fi;
        n_op    = r_op;
        n_slot  = r_slot;
        n_key   = r_key;
        n_gw    = r_gw;
        n_amac  = r_amac;
        n_port  = r_port;
        n_dmac  = r_dmac;
        n_ftype = r_ftype;
        n_sip   = r_sip;
        n_dip   = r_dip;
        n_pend  = r_pend;
        n_pport = r_pport;
        n_pmac  = r_pmac;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata = r_odata;
        n_olast = r_olast;

        unique case (r_state)
            srafd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_op    = i_s_tdata[1:0];
                    n_slot  = i_s_tdata[5:2];
                    n_key   = i_s_tdata[37:6];
                    n_gw    = i_s_tdata[69:38];
                    n_amac  = i_s_tdata[117:70];
                    n_port  = i_s_tdata[121:118];
                    n_dmac  = i_s_tdata[169:122];
                    n_ftype = i_s_tdata[185:170];
                    n_sip   = i_s_tdata[217:186];
                    n_dip   = i_s_tdata[249:218];
                    n_idx   = '0;
                    n_ph    = 1'b0;
                    n_state = (i_s_tdata[1:0] == srafd_pkg::OP_FWD) ? srafd_pkg::ST_L1
                                                                    : srafd_pkg::ST_WR;
                end
            end
            srafd_pkg::ST_WR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_WRITTEN, '0, '0, '0);
                    n_olast  = 1'b1;
                    n_state  = srafd_pkg::ST_IDLE;
                end
            end
            srafd_pkg::ST_FE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    n_odata  = r_pend ? srafd_pkg::pack_out(srafd_pkg::ACT_FLOOD, r_pport,
                                                            r_pmac, r_dmac)
                                      : srafd_pkg::pack_out(srafd_pkg::ACT_FLOOD_0, '0, '0, '0);
                    n_state  = srafd_pkg::ST_IDLE;
                end
            end
            default: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (out_free) begin
                    n_ph = 1'b0;
                    unique case (r_state)
                        srafd_pkg::ST_L1: begin
                            if (cmp_eq) begin
                                if (r_ftype != srafd_pkg::ETHERTYPE_IPV4) begin
                                    n_ovalid = 1'b1;
                                    n_olast  = 1'b1;
                                    n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_NOT_IPV4,
                                                                   '0, '0, '0);
                                    n_state  = srafd_pkg::ST_IDLE;
                                end else begin
                                    n_idx   = '0;
                                    n_state = srafd_pkg::ST_R1;
                                end
                            end else if (l_last) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_NOT_LOCAL,
                                                               '0, '0, '0);
                                n_state  = srafd_pkg::ST_IDLE;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        srafd_pkg::ST_R1: begin
                            if (cmp_eq) begin
                                n_gw    = rq_gw;
                                n_port  = rq_port;
                                n_idx   = '0;
                                n_state = srafd_pkg::ST_A1;
                            end else if (r_last) begin
                                n_fi    = '0;
                                n_pend  = 1'b0;
                                n_state = srafd_pkg::ST_FA;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        srafd_pkg::ST_A1: begin
                            if (cmp_eq) begin
                                n_amac  = aq_mac;
                                n_idx   = '0;
                                n_state = srafd_pkg::ST_L2;
                            end else if (a_last) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_NO_ARP,
                                                               '0, '0, '0);
                                n_state  = srafd_pkg::ST_IDLE;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        srafd_pkg::ST_L2: begin
                            if (cmp_eq) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_SELF,
                                                               '0, '0, '0);
                                n_state  = srafd_pkg::ST_IDLE;
                            end else if (l_last) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b1;
                                n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_UNICAST,
                                                               r_port, r_amac, r_dmac);
                                n_state  = srafd_pkg::ST_IDLE;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        srafd_pkg::ST_FA: begin
                            // skip invalid entries and the frame's own source
                            if (r_av[r_fi] && !cmp_eq) begin
                                n_key   = aq_ip;
                                n_amac  = aq_mac;
                                n_idx   = '0;
                                n_state = srafd_pkg::ST_FG;
                            end else if (fi_last) begin
                                n_state = srafd_pkg::ST_FE;
                            end else begin
                                n_fi = r_fi + 1'b1;
                            end
                        end
                        srafd_pkg::ST_FG: begin
                            if (cmp_eq) begin
                                n_port  = rq_port;
                                n_idx   = '0;
                                n_state = srafd_pkg::ST_FL;
                            end else if (r_last) begin
                                n_fi    = r_fi + 1'b1;
                                n_state = fi_last ? srafd_pkg::ST_FE : srafd_pkg::ST_FA;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        srafd_pkg::ST_FL: begin
                            if (cmp_eq || l_last) begin
                                if (!cmp_eq) begin
                                    // qualified: release the held copy, hold this one
                                    if (r_pend) begin
                                        n_ovalid = 1'b1;
                                        n_olast  = 1'b0;
                                        n_odata  = srafd_pkg::pack_out(srafd_pkg::ACT_FLOOD,
                                                                       r_pport, r_pmac, r_dmac);
                                    end
                                    n_pend  = 1'b1;
                                    n_pport = r_port;
                                    n_pmac  = r_amac;
                                end
                                n_fi    = r_fi + 1'b1;
                                n_state = fi_last ? srafd_pkg::ST_FE : srafd_pkg::ST_FA;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        default: begin
                            n_state = srafd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srafd_pkg::ST_IDLE;
            r_ph     <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_lv     <= '0;
            r_rv     <= '0;
            r_av     <= '0;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (l_we) r_lv[LAW'(r_slot)] <= 1'b1;
            if (r_we) r_rv[RAW'(r_slot)] <= 1'b1;
            if (a_we) r_av[AAW'(r_slot)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_fi    <= n_fi;
        r_op    <= n_op;
        r_slot  <= n_slot;
        r_key   <= n_key;
        r_gw    <= n_gw;
        r_amac  <= n_amac;
        r_port  <= n_port;
        r_dmac  <= n_dmac;
        r_ftype <= n_ftype;
        r_sip   <= n_sip;
        r_dip   <= n_dip;
        r_pport <= n_pport;
        r_pmac  <= n_pmac;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end
endmodule

// ----- sv/srafd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the static route / ARP decision block, bound to the top level.
// Depends on srafd_pkg and static_route_arp_forward_decision_top.
module srafd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata,
    input logic         o_m_tlast
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_zero_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != srafd_pkg::ACT_UNICAST
            && o_m_tdata[2:0] != srafd_pkg::ACT_FLOOD |-> o_m_tdata[6:3] == 4'd0)
        else $error("port set on a non-sending result");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != srafd_pkg::ACT_FLOOD |-> o_m_tlast)
        else $error("single result without tlast");

    a_busy_in_flood: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken while flood copies remain");
endmodule

bind static_route_arp_forward_decision_top srafd_checker u_srafd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_s_tready(o_s_tready), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
);

// ----- verif/srafd_decision_checker.sv -----
`timescale 1ns / 1ps
// Checker for the static route / ARP decision block: watches both streams,
// predicts each decision from its own table copy and compares. Depends on srafd_pkg.
module srafd_decision_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [255:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [103:0] i_m_tdata,
    input  logic         i_m_tlast,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [srafd_pkg::ACT_W-1:0]  action;
        logic [srafd_pkg::PORT_W-1:0] port;
        logic [srafd_pkg::MAC_W-1:0]  dmac;
        logic [srafd_pkg::MAC_W-1:0]  smac;
        logic                         last;
    } t_decision;

    logic [srafd_pkg::MAC_W-1:0]  lcl_mac [16];
    logic                         lcl_ok  [16];
    logic [srafd_pkg::IP_W-1:0]   rt_dst  [16];
    logic [srafd_pkg::IP_W-1:0]   rt_gw   [16];
    logic [srafd_pkg::PORT_W-1:0] rt_port [16];
    logic                         rt_ok   [16];
    logic [srafd_pkg::IP_W-1:0]   nb_ip   [16];
    logic [srafd_pkg::MAC_W-1:0]  nb_mac  [16];
    logic                         nb_ok   [16];

    t_decision expected_decisions[$];

    function automatic bit is_local_mac(logic [srafd_pkg::MAC_W-1:0] mac);
        foreach (lcl_ok[i]) if (lcl_ok[i] && lcl_mac[i] == mac) return 1;
        return 0;
    endfunction

    function automatic t_decision mk(logic [2:0] act, logic [3:0] p,
                                      logic [47:0] d, logic [47:0] s, logic l);
        t_decision r;
        r.action = act; r.port = p; r.dmac = d; r.smac = s; r.last = l;
        return r;
    endfunction

    // Apply one request to the table copy and queue the decisions it causes.
    task automatic predict_decision(logic [255:0] req);
        logic [1:0]  op;
        logic [3:0]  slot, pnum;
        logic [31:0] key, gw, sip, dip;
        logic [47:0] mval, fdmac;
        logic [15:0] ftype;
        logic [3:0]  held_port;
        int r, a, g, held;
        op = req[1:0]; slot = req[5:2]; key = req[37:6]; gw = req[69:38];
        mval = req[117:70]; pnum = req[121:118]; fdmac = req[169:122];
        ftype = req[185:170]; sip = req[217:186]; dip = req[249:218];
        r = -1; a = -1; held = -1; held_port = '0;
        case (op)
            srafd_pkg::OP_LOCAL: begin
                lcl_mac[slot] = mval; lcl_ok[slot] = 1;
                expected_decisions.push_back(mk(srafd_pkg::ACT_WRITTEN, '0, '0, '0, 1'b1));
            end
            srafd_pkg::OP_ROUTE: begin
                rt_dst[slot] = key; rt_gw[slot] = gw; rt_port[slot] = pnum; rt_ok[slot] = 1;
                expected_decisions.push_back(mk(srafd_pkg::ACT_WRITTEN, '0, '0, '0, 1'b1));
            end
            srafd_pkg::OP_ARP: begin
                nb_ip[slot] = key; nb_mac[slot] = mval; nb_ok[slot] = 1;
                expected_decisions.push_back(mk(srafd_pkg::ACT_WRITTEN, '0, '0, '0, 1'b1));
            end
            default: begin
                if (!is_local_mac(fdmac)) begin
                    expected_decisions.push_back(
                        mk(srafd_pkg::ACT_NOT_LOCAL, '0, '0, '0, 1'b1));
                end else if (ftype != srafd_pkg::ETHERTYPE_IPV4) begin
                    expected_decisions.push_back(
                        mk(srafd_pkg::ACT_NOT_IPV4, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < 16 && r < 0; i++)
                        if (rt_ok[i] && rt_dst[i] == dip) r = i;
                    if (r >= 0) begin
                        for (int i = 0; i < 16 && a < 0; i++)
                            if (nb_ok[i] && nb_ip[i] == rt_gw[r]) a = i;
                        if (a < 0)
                            expected_decisions.push_back(
                                mk(srafd_pkg::ACT_NO_ARP, '0, '0, '0, 1'b1));
                        else if (is_local_mac(nb_mac[a]))
                            expected_decisions.push_back(
                                mk(srafd_pkg::ACT_SELF, '0, '0, '0, 1'b1));
                        else
                            expected_decisions.push_back(
                                mk(srafd_pkg::ACT_UNICAST, rt_port[r], nb_mac[a], fdmac,
                                   1'b1));
                    end else begin
                        // Flood: hold one copy back so the final one carries last.
                        for (int i = 0; i < 16; i++) begin
                            g = -1;
                            if (!nb_ok[i] || nb_ip[i] == sip) continue;
                            for (int j = 0; j < 16 && g < 0; j++)
                                if (rt_ok[j] && rt_gw[j] == nb_ip[i]) g = j;
                            if (g < 0 || is_local_mac(nb_mac[i])) continue;
                            if (held >= 0)
                                expected_decisions.push_back(
                                    mk(srafd_pkg::ACT_FLOOD, held_port, nb_mac[held], fdmac,
                                       1'b0));
                            held = i; held_port = rt_port[g];
                        end
                        if (held < 0)
                            expected_decisions.push_back(
                                mk(srafd_pkg::ACT_FLOOD_0, '0, '0, '0, 1'b1));
                        else
                            expected_decisions.push_back(
                                mk(srafd_pkg::ACT_FLOOD, held_port, nb_mac[held], fdmac,
                                   1'b1));
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_decision got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
            foreach (lcl_ok[i]) begin
                lcl_ok[i] = 0; rt_ok[i] = 0; nb_ok[i] = 0;
            end
        end else begin
            // Compare before predicting: a result never shares an edge with its request.
            if (i_m_tvalid && i_m_tready) begin
                got = mk(i_m_tdata[2:0], i_m_tdata[6:3], i_m_tdata[54:7],
                         i_m_tdata[102:55], i_m_tlast);
                if (expected_decisions.size() == 0) begin
                    $display("%0t: unexpected decision, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got !== want) begin
                        $display("%0t: decision mismatch, expected %h actual %h",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_decision(i_s_tdata);
            o_pending <= expected_decisions.size();
        end
    end

endmodule

// ----- verif/static_route_arp_forward_decision_top_tb.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the static route / ARP decision block.
// Depends on srafd_pkg, srafd_decision_checker and the block itself.
module static_route_arp_forward_decision_top_tb;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;

    // Idle odds in percent, changed per phase.
    int send_idle = 6;
    int recv_idle = 54;
    bit hold_recv = 0;
    int quiet_cycles = 0;

    // Small value pools so random requests hit the loaded tables.
    logic [31:0] ip_pool  [8];
    logic [47:0] mac_pool [8];

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    static_route_arp_forward_decision_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast)
    );

    srafd_decision_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random ready, forced low while a long hold-off runs.
    always @(negedge i_clk) begin
        m_tready <= i_rst_n && !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: end the run when no request or result moves for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_recv)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("static_route_arp_forward_decision_top verification failed");
            $finish;
        end
    end

    // Offer one request, idling first at random, and hold it until accepted.
    // Ready only moves at the rising edge, so its value at the falling edge
    // tells whether the coming edge takes the request.
    task automatic send_request(logic [255:0] req);
        bit taken;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge i_clk);
        end
        s_tdata  <= req;
        s_tvalid <= 1;
        do begin
            taken = s_tready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [255:0] pack_request(
        logic [1:0] op, logic [3:0] slot, logic [31:0] key, logic [31:0] gw,
        logic [47:0] mval, logic [3:0] pnum, logic [47:0] fdmac, logic [15:0] ftype,
        logic [31:0] sip, logic [31:0] dip);
        return {6'd0, dip, sip, ftype, fdmac, pnum, mval, gw, key, slot, op};
    endfunction

    // Mostly well-formed writes and forwards drawn from the pools, some raw noise.
    function automatic logic [255:0] random_request();
        logic [255:0] raw;
        logic [1:0]   op;
        logic [47:0]  fdmac;
        logic [15:0]  ftype;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        raw[255:250] = '0;
        if ($urandom_range(9) == 0) return raw;
        op    = $urandom_range(3) == 0 ? srafd_pkg::OP_FWD : 2'($urandom_range(3));
        fdmac = $urandom_range(7) == 0 ? raw[169:122] : mac_pool[$urandom_range(3)];
        ftype = $urandom_range(7) == 0 ? raw[185:170] : srafd_pkg::ETHERTYPE_IPV4;
        return pack_request(op, raw[5:2], ip_pool[$urandom_range(7)],
            ip_pool[$urandom_range(7)], mac_pool[$urandom_range(7)], raw[121:118],
            fdmac, ftype, ip_pool[$urandom_range(7)],
            $urandom_range(4) == 0 ? raw[249:218] : ip_pool[$urandom_range(7)]);
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        foreach (ip_pool[i]) begin
            ip_pool[i]  = $urandom;
            mac_pool[i] = {$urandom, $urandom};
        end
        ip_pool[0] = '0; ip_pool[1] = '1; mac_pool[0] = '1; mac_pool[7] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: drops on empty tables, then each table edge and each decision.
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0],
                                  srafd_pkg::ETHERTYPE_IPV4, 0, 0));
        send_request(pack_request(srafd_pkg::OP_LOCAL, 0, 0, 0, mac_pool[0], 0, 0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_LOCAL, 15, 0, 0, mac_pool[1], 15,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0], 16'hffff,
                                  0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[1],
                                  srafd_pkg::ETHERTYPE_IPV4, ip_pool[2], ip_pool[3]));
        send_request(pack_request(srafd_pkg::OP_ROUTE, 0, ip_pool[3], ip_pool[4], 0, 5,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0],
                                  srafd_pkg::ETHERTYPE_IPV4, 0, ip_pool[3]));
        send_request(pack_request(srafd_pkg::OP_ARP, 15, ip_pool[4], 0, mac_pool[0], 0,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0],
                                  srafd_pkg::ETHERTYPE_IPV4, 0, ip_pool[3]));
        send_request(pack_request(srafd_pkg::OP_ARP, 15, ip_pool[4], 0, mac_pool[2], 0,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0],
                                  srafd_pkg::ETHERTYPE_IPV4, 0, ip_pool[3]));
        send_request(pack_request(srafd_pkg::OP_ROUTE, 15, ip_pool[1], ip_pool[0], 0, 15,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_ARP, 0, ip_pool[0], 0, mac_pool[7], 0,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_ARP, 3, ip_pool[5], 0, mac_pool[3], 0,
                                  0, 0, 0, 0));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[0],
                                  srafd_pkg::ETHERTYPE_IPV4, ip_pool[6], ip_pool[7]));
        send_request(pack_request(srafd_pkg::OP_FWD, 0, 0, 0, 0, 0, mac_pool[1],
                                  srafd_pkg::ETHERTYPE_IPV4, ip_pool[4], ip_pool[7]));
        send_request('1 >> 6);

        // Random phases; during the first one the receiver stalls long once.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 6 : (phase == 1 ? 54 : 0);
            recv_idle = phase == 0 ? 54 : (phase == 1 ? 6 : 0);
            if (phase == 0) begin
                fork
                    begin
                        hold_recv = 1;
                        repeat (600) @(posedge i_clk);
                        hold_recv = 0;
                    end
                join_none
            end
            repeat (44) send_request(random_request());
            drain();
        end

        if (fail_count == 0)
            $display("static_route_arp_forward_decision_top verification clean");
        else
            $display("static_route_arp_forward_decision_top verification failed");
        $finish;
    end

endmodule
